@@ src/lcra_pkg.sv @@
// Shared types and constants for the largest connected region area unit.
package lcra_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;
    localparam int AREA_W       = 13;
    localparam int DIM_W        = 7;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
    localparam logic [DIM_W-1:0]     DIM_RESET = 7'd64;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_START,
        S_NB_RD,
        S_NB_CHK,
        S_F_RD,
        S_F_CHK,
        S_C_RD,
        S_C_WR,
        S_SZ_A,
        S_SZ_B,
        S_SZ_CMP,
        S_FINISH
    } state_t;

    typedef enum logic {
        NB_UP,
        NB_LEFT
    } nb_t;

endpackage

@@ src/largest_connected_region_area_unit.sv @@
// Top level: union-find labeling over a raster image, reports the largest region area.
//
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------
//  pixel     | pixel_valid/pixel_stall| pixel_set
//  area      | area_valid/area_stall  | largest_area
//  cfg       | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// A clear pixel passes through S_START and S_FINISH. A set pixel also visits each neighbor
// (upper, left): one outside the image is skipped, one inside is read and checked; a set
// neighbor then adds two finds, each a walk to the root and a path compression, and a size
// merge when the roots differ. The finds use the single read port of the parent memory.
// A write to the column count costs one extra remainder pass on the next pixel.
// Reset clears control state only; the memories need no clearing pass.
// A result waiting on area_stall holds the block at the last pixel of the next image.
module largest_connected_region_area_unit
    import lcra_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pixel_valid,
    output logic                 pixel_stall,
    input  logic                 pixel_set,
    output logic                 area_valid,
    input  logic                 area_stall,
    output logic [AREA_W-1:0]    largest_area,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int SZ_W   = $clog2(CELLS + 1);
    localparam int COL_W  = $clog2(MAX_COLS + 1);
    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int CNT_W  = $clog2(ADDR_W + 1);

    state_t state_reg, state_next;
    nb_t    nb_reg, nb_next;

    logic [DIM_W-1:0]  rows_reg, cols_reg;
    logic              resync_reg, resync_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [SZ_W-1:0]   best_reg, best_next;
    logic              pix_reg, pix_next;
    logic [ADDR_W-1:0] b_reg, b_next;
    logic [ADDR_W-1:0] cur_reg, cur_next;
    logic [ADDR_W-1:0] fx_reg, fx_next;
    logic [ADDR_W-1:0] root_reg, root_next;
    logic              which_reg, which_next;
    logic [ADDR_W-1:0] ra_reg, ra_next;
    logic [ADDR_W-1:0] rb_reg, rb_next;
    logic [SZ_W-1:0]   sa_reg, sa_next;
    logic [COL_W-1:0]  rem_reg, rem_next;
    logic [ADDR_W-1:0] dq_reg, dq_next;
    logic [CNT_W-1:0]  dcnt_reg, dcnt_next;
    logic              area_valid_reg, area_valid_next;
    logic [AREA_W-1:0] area_reg, area_next;

    logic [COL_W-1:0]  cols_eff;
    logic [ROW_W-1:0]  rows_eff;
    logic [31:0]       total;
    logic              is_last;
    logic              has_up;
    logic              has_left;
    logic [COL_W:0]    div_t;
    logic [SZ_W-1:0]   sum_sz;
    logic [31:0]       best_ext;

    // memory ports
    logic              land_we, par_we, sz_we;
    logic [ADDR_W-1:0] land_waddr, par_waddr, sz_waddr;
    logic              land_wdata;
    logic [ADDR_W-1:0] par_wdata;
    logic [SZ_W-1:0]   sz_wdata;
    logic [ADDR_W-1:0] land_raddr, par_raddr, sz_raddr;
    logic              land_rdata;
    logic [ADDR_W-1:0] par_rdata;
    logic [SZ_W-1:0]   sz_rdata;

    lcra_ram #(.W(1), .DEPTH(CELLS), .AW(ADDR_W)) u_land (
        .clk(clk), .we(land_we), .waddr(land_waddr), .wdata(land_wdata),
        .raddr(land_raddr), .rdata(land_rdata)
    );

    lcra_ram #(.W(ADDR_W), .DEPTH(CELLS), .AW(ADDR_W)) u_parent (
        .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
        .raddr(par_raddr), .rdata(par_rdata)
    );

    lcra_ram #(.W(SZ_W), .DEPTH(CELLS), .AW(ADDR_W)) u_size (
        .clk(clk), .we(sz_we), .waddr(sz_waddr), .wdata(sz_wdata),
        .raddr(sz_raddr), .rdata(sz_rdata)
    );

    // clamp the configured dimensions
    always_comb
    begin
        if (cols_reg == '0)
            cols_eff = COL_W'(1);
        else if (32'(cols_reg) > MAX_COLS)
            cols_eff = COL_W'(MAX_COLS);
        else
            cols_eff = COL_W'(cols_reg);

        if (rows_reg == '0)
            rows_eff = ROW_W'(1);
        else if (32'(rows_reg) > MAX_ROWS)
            rows_eff = ROW_W'(MAX_ROWS);
        else
            rows_eff = ROW_W'(rows_reg);
    end

    assign total    = 32'(rows_eff) * 32'(cols_eff);
    assign is_last  = (32'(pos_reg) + 32'd1) >= total;
    assign has_up   = 32'(pos_reg) >= 32'(cols_eff);
    assign has_left = col_reg != '0;
    assign div_t    = {rem_reg, dq_reg[ADDR_W-1]};
    assign sum_sz   = sa_reg + sz_rdata;
    assign best_ext = 32'(best_reg);

    assign cfg_ready    = 1'b1;
    assign pixel_stall  = (state_reg != S_IDLE);
    assign area_valid   = area_valid_reg;
    assign largest_area = area_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= DIM_RESET;
            cols_reg <= DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_ROWS)
                rows_reg <= cfg_data;
            else if (cfg_index == CFG_COLS)
                cols_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            nb_reg         <= NB_UP;
            resync_reg     <= 1'b0;
            pos_reg        <= '0;
            col_reg        <= '0;
            best_reg       <= '0;
            area_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            nb_reg         <= nb_next;
            resync_reg     <= (cfg_valid && cfg_ready && cfg_index == CFG_COLS)
                              ? 1'b1 : resync_next;
            pos_reg        <= pos_next;
            col_reg        <= col_next;
            best_reg       <= best_next;
            area_valid_reg <= area_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg   <= pix_next;
        b_reg     <= b_next;
        cur_reg   <= cur_next;
        fx_reg    <= fx_next;
        root_reg  <= root_next;
        which_reg <= which_next;
        ra_reg    <= ra_next;
        rb_reg    <= rb_next;
        sa_reg    <= sa_next;
        rem_reg   <= rem_next;
        dq_reg    <= dq_next;
        dcnt_reg  <= dcnt_next;
        area_reg  <= area_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        nb_next         = nb_reg;
        resync_next     = resync_reg;
        pos_next        = pos_reg;
        col_next        = col_reg;
        best_next       = best_reg;
        pix_next        = pix_reg;
        b_next          = b_reg;
        cur_next        = cur_reg;
        fx_next         = fx_reg;
        root_next       = root_reg;
        which_next      = which_reg;
        ra_next         = ra_reg;
        rb_next         = rb_reg;
        sa_next         = sa_reg;
        rem_next        = rem_reg;
        dq_next         = dq_reg;
        dcnt_next       = dcnt_reg;
        area_next       = area_reg;
        area_valid_next = area_valid_reg && area_stall;

        land_we    = 1'b0;
        land_waddr = pos_reg;
        land_wdata = pix_reg;
        land_raddr = b_reg;
        par_we     = 1'b0;
        par_waddr  = pos_reg;
        par_wdata  = pos_reg;
        par_raddr  = cur_reg;
        sz_we      = 1'b0;
        sz_waddr   = pos_reg;
        sz_wdata   = SZ_W'(1);
        sz_raddr   = ra_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (pixel_valid)
                begin
                    pix_next  = pixel_set;
                    nb_next   = NB_UP;
                    rem_next  = '0;
                    dq_next   = pos_reg;
                    dcnt_next = '0;
                    state_next = resync_reg ? S_DIV : S_START;
                end
            end

            S_DIV:
            begin
                // one restoring step of pos % cols
                if (div_t >= {1'b0, cols_eff})
                    rem_next = COL_W'(div_t - {1'b0, cols_eff});
                else
                    rem_next = COL_W'(div_t);
                dq_next   = dq_reg << 1;
                dcnt_next = dcnt_reg + CNT_W'(1);
                if (32'(dcnt_reg) == ADDR_W - 1)
                begin
                    col_next    = rem_next;
                    resync_next = 1'b0;
                    state_next  = S_START;
                end
            end

            S_START:
            begin
                land_we = 1'b1;
                if (pix_reg)
                begin
                    par_we = 1'b1;
                    sz_we  = 1'b1;
                    if (best_reg == '0)
                        best_next = SZ_W'(1);
                    state_next = S_NB_RD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_NB_RD:
            begin
                if (nb_reg == NB_UP)
                begin
                    if (has_up)
                    begin
                        b_next     = ADDR_W'(32'(pos_reg) - 32'(cols_eff));
                        land_raddr = b_next;
                        state_next = S_NB_CHK;
                    end
                    else
                    begin
                        nb_next = NB_LEFT;
                    end
                end
                else if (has_left)
                begin
                    b_next     = pos_reg - ADDR_W'(1);
                    land_raddr = b_next;
                    state_next = S_NB_CHK;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_NB_CHK:
            begin
                if (land_rdata)
                begin
                    cur_next   = pos_reg;
                    fx_next    = pos_reg;
                    which_next = 1'b0;
                    state_next = S_F_RD;
                end
                else if (nb_reg == NB_UP)
                begin
                    nb_next    = NB_LEFT;
                    state_next = S_NB_RD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_F_RD:
            begin
                state_next = S_F_CHK;
            end

            S_F_CHK:
            begin
                if (par_rdata == cur_reg)
                begin
                    root_next  = cur_reg;
                    cur_next   = fx_reg;
                    state_next = S_C_RD;
                end
                else
                begin
                    cur_next   = par_rdata;
                    state_next = S_F_RD;
                end
            end

            S_C_RD:
            begin
                if (cur_reg == root_reg)
                begin
                    if (!which_reg)
                    begin
                        ra_next    = root_reg;
                        cur_next   = b_reg;
                        fx_next    = b_reg;
                        which_next = 1'b1;
                        state_next = S_F_RD;
                    end
                    else if (ra_reg == root_reg)
                    begin
                        // already one region
                        if (nb_reg == NB_UP)
                        begin
                            nb_next    = NB_LEFT;
                            state_next = S_NB_RD;
                        end
                        else
                        begin
                            state_next = S_FINISH;
                        end
                    end
                    else
                    begin
                        rb_next    = root_reg;
                        state_next = S_SZ_A;
                    end
                end
                else
                begin
                    state_next = S_C_WR;
                end
            end

            S_C_WR:
            begin
                par_we     = 1'b1;
                par_waddr  = cur_reg;
                par_wdata  = root_reg;
                cur_next   = par_rdata;
                state_next = S_C_RD;
            end

            S_SZ_A:
            begin
                sz_raddr   = ra_reg;
                state_next = S_SZ_B;
            end

            S_SZ_B:
            begin
                sa_next    = sz_rdata;
                sz_raddr   = rb_reg;
                state_next = S_SZ_CMP;
            end

            S_SZ_CMP:
            begin
                par_we   = 1'b1;
                sz_we    = 1'b1;
                sz_wdata = sum_sz;
                if (sa_reg < sz_rdata)
                begin
                    par_waddr = ra_reg;
                    par_wdata = rb_reg;
                    sz_waddr  = rb_reg;
                end
                else
                begin
                    par_waddr = rb_reg;
                    par_wdata = ra_reg;
                    sz_waddr  = ra_reg;
                end
                if (sum_sz > best_reg)
                    best_next = sum_sz;
                if (nb_reg == NB_UP)
                begin
                    nb_next    = NB_LEFT;
                    state_next = S_NB_RD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (is_last)
                begin
                    if (!(area_valid_reg && area_stall))
                    begin
                        area_next       = best_ext[AREA_W-1:0];
                        area_valid_next = 1'b1;
                        pos_next        = '0;
                        col_next        = '0;
                        best_next       = '0;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    pos_next = pos_reg + ADDR_W'(1);
                    if ((32'(col_reg) + 32'd1) >= 32'(cols_eff))
                        col_next = '0;
                    else
                        col_next = col_reg + COL_W'(1);
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_reg) < CELLS)
        else $error("pixel position out of range");

    a_col_track: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !resync_reg) |-> (col_reg < cols_eff))
        else $error("column counter out of step");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(area_valid) |-> $past(state_reg == S_FINISH))
        else $error("result raised outside the last pixel");

    a_merge_roots: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SZ_CMP) |-> (ra_reg != rb_reg))
        else $error("merging a region with itself");
`endif

endmodule

@@ src/lcra_ram.sv @@
// Single-port-write, single-read synchronous RAM with registered read data.
module lcra_ram #(
    parameter int W     = 1,
    parameter int DEPTH = 2,
    parameter int AW    = 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
